// File: hw/rtl/rsem_pkg.sv
// shared types and constants of the running standard error monitor
`default_nettype none
package rsem_pkg;

    localparam int SQ_W     = 64;
    localparam int SE_W     = 20;
    localparam int WID_W    = 22;
    localparam int TOL_W    = 22;
    localparam int SQRT_W   = 64;
    localparam int SQRT_STEPS = SQRT_W / 2;
    localparam int ZMUL_W   = 32;
    localparam int Z_SHIFT  = 10;

    localparam logic [TOL_W-1:0]  TOL_RESET = 22'd1024;
    localparam logic [SE_W-1:0]   SE_MAX    = 20'hFFFFF;
    localparam logic [ZMUL_W-1:0] Z_NUM     = 32'd2638;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQUARE,
        OP_ACCUM,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_DIV1_INIT,
        OP_DIV_STEP,
        OP_DIV2_INIT,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SE,
        OP_WIDTH,
        OP_ZERO,
        OP_PUBLISH
    } t_op;

    typedef struct packed {
        logic count_lt2;
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/rsem_in_if.sv
// input channel: command and sample word
`default_nettype none
interface rsem_in_if #(
    parameter int SAMPLE_WIDTH = 20
);
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rsem_out_if.sv
// output channel: statistics word
`default_nettype none
interface rsem_out_if #(
    parameter int COUNT_WIDTH = 24
);
    logic                   valid;
    logic                   ready;
    logic [19:0]            std_error;
    logic [21:0]            interval_width;
    logic [COUNT_WIDTH-1:0] count_out;
    logic                   converged;
    logic                   count_full;

    modport source (output valid, output std_error, output interval_width,
                    output count_out, output converged, output count_full,
                    input ready);
    modport sink   (input valid, input std_error, input interval_width,
                    input count_out, input converged, input count_full,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rsem_ctrl.sv
// sequencer for the accumulate, multiply, divide and square root steps
`default_nettype none
module rsem_ctrl #(
    parameter int SUM_W = 44,
    parameter int DIV_W = 88
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire rsem_pkg::t_status i_status,
    output rsem_pkg::t_op         o_op
);
    localparam int CNT_W = $clog2(DIV_W);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ACC, S_CHK, S_MUL, S_DIV1I, S_DIV1, S_DIV2I, S_DIV2,
        S_SQRTI, S_SQRT, S_SE, S_WID, S_ZERO, S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             last;

    assign last        = (r_cnt == '0);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = rsem_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = rsem_pkg::OP_LOAD;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_op    = rsem_pkg::OP_SQUARE;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_op    = rsem_pkg::OP_ACCUM;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_op    = rsem_pkg::OP_MUL_INIT;
                n_cnt   = CNT_W'(SUM_W - 1);
                n_state = i_status.count_lt2 ? S_ZERO : S_MUL;
            end
            S_MUL: begin
                o_op  = rsem_pkg::OP_MUL_STEP;
                n_cnt = r_cnt - 1'b1;
                if (last) n_state = S_DIV1I;
            end
            S_DIV1I: begin
                o_op    = rsem_pkg::OP_DIV1_INIT;
                n_cnt   = CNT_W'(DIV_W - 1);
                n_state = S_DIV1;
            end
            S_DIV1: begin
                o_op  = rsem_pkg::OP_DIV_STEP;
                n_cnt = r_cnt - 1'b1;
                if (last) n_state = S_DIV2I;
            end
            S_DIV2I: begin
                o_op    = rsem_pkg::OP_DIV2_INIT;
                n_cnt   = CNT_W'(DIV_W - 1);
                n_state = S_DIV2;
            end
            S_DIV2: begin
                o_op  = rsem_pkg::OP_DIV_STEP;
                n_cnt = r_cnt - 1'b1;
                if (last) n_state = S_SQRTI;
            end
            S_SQRTI: begin
                o_op    = rsem_pkg::OP_SQRT_INIT;
                n_cnt   = CNT_W'(rsem_pkg::SQRT_STEPS - 1);
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_op  = rsem_pkg::OP_SQRT_STEP;
                n_cnt = r_cnt - 1'b1;
                if (last) n_state = S_SE;
            end
            S_SE: begin
                o_op    = rsem_pkg::OP_SE;
                n_state = S_WID;
            end
            S_WID: begin
                o_op    = rsem_pkg::OP_WIDTH;
                n_state = S_FIN;
            end
            S_ZERO: begin
                o_op    = rsem_pkg::OP_ZERO;
                n_state = S_FIN;
            end
            S_FIN: begin
                // output register free or emptying this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_op        = rsem_pkg::OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/rsem_dpath.sv
// accumulators, shift-add multiplier, restoring divider and square root
`default_nettype none
module rsem_dpath #(
    parameter int SAMPLE_WIDTH = 20,
    parameter int COUNT_WIDTH  = 24,
    parameter int SUM_W        = 44,
    parameter int DIV_W        = 88
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire rsem_pkg::t_op                  i_op,
    input  wire logic                           i_cmd,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_cfg_we,
    input  wire logic [rsem_pkg::TOL_W-1:0]     i_cfg_data,
    output rsem_pkg::t_status                   o_status,
    output logic [rsem_pkg::SE_W-1:0]           o_std_error,
    output logic [rsem_pkg::WID_W-1:0]          o_interval_width,
    output logic [COUNT_WIDTH-1:0]              o_count_out,
    output logic                                o_converged,
    output logic                                o_count_full
);
    localparam int SQ_W  = rsem_pkg::SQ_W;
    localparam int RT_W  = rsem_pkg::SQRT_W;
    localparam int DVW   = 2 * COUNT_WIDTH;
    localparam int SMP_SQ_W = 2 * SAMPLE_WIDTH;

    logic [rsem_pkg::TOL_W-1:0]     r_tol;
    logic                           r_cmd;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic [SMP_SQ_W-1:0]            r_sq;
    logic signed [SUM_W-1:0]        r_sum;
    logic [SQ_W-1:0]                r_sqsum;
    logic [COUNT_WIDTH-1:0]         r_count;
    logic                           r_full;
    logic [SUM_W-1:0]               r_mag;
    logic [SUM_W-1:0]               r_mbits;
    logic [2*SUM_W-1:0]             r_prod;
    logic [DIV_W-1:0]               r_z;
    logic [DVW-1:0]                 r_rem;
    logic [DVW-1:0]                 r_div;
    logic [RT_W-1:0]                r_v;
    logic [RT_W-1:0]                r_res;
    logic [RT_W-1:0]                r_bit;
    logic [rsem_pkg::SE_W-1:0]      r_se;
    logic [rsem_pkg::WID_W-1:0]     r_wid;
    logic                           r_conv;

    logic [SAMPLE_WIDTH-1:0]        smp_mag;
    logic [SUM_W-1:0]               sum_mag;
    logic [SQ_W:0]                  sq_add;
    logic [DVW:0]                   div_t;
    logic                           div_ge;
    logic [SQ_W-1:0]                q_sat;
    logic [SQ_W-1:0]                d_var;
    logic [RT_W-1:0]                rt_try;
    logic [rsem_pkg::ZMUL_W-1:0]    z_prod;
    logic [rsem_pkg::WID_W-1:0]     wid_val;

    assign smp_mag = r_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-r_sample)
                                              : SAMPLE_WIDTH'(r_sample);
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign sq_add  = {1'b0, r_sqsum} + (SQ_W+1)'(r_sq);
    assign div_t   = {r_rem, r_z[DIV_W-1]};
    assign div_ge  = (div_t >= {1'b0, r_div});
    // quotient above 64 bits counts as saturated
    assign q_sat   = ((r_z >> SQ_W) != '0) ? '1 : r_z[SQ_W-1:0];
    assign d_var   = (q_sat <= r_sqsum) ? (r_sqsum - q_sat) : '0;
    assign rt_try  = r_res + r_bit;
    assign z_prod  = rsem_pkg::ZMUL_W'(r_se) * rsem_pkg::Z_NUM;
    assign wid_val = z_prod[rsem_pkg::ZMUL_W-1:rsem_pkg::Z_SHIFT];

    assign o_status.count_lt2 = (r_count < COUNT_WIDTH'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= rsem_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sqsum <= '0;
            r_count <= '0;
            r_full  <= 1'b0;
        end else if (i_op == rsem_pkg::OP_ACCUM) begin
            if (r_cmd) begin
                r_sum   <= '0;
                r_sqsum <= '0;
                r_count <= '0;
                r_full  <= 1'b0;
            end else if (&r_count) begin
                r_full <= 1'b1;
            end else begin
                r_sum   <= r_sum + SUM_W'(r_sample);
                r_sqsum <= sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
                r_count <= r_count + 1'b1;
                r_full  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            rsem_pkg::OP_LOAD: begin
                r_cmd    <= i_cmd;
                r_sample <= i_sample;
            end
            rsem_pkg::OP_SQUARE: begin
                r_sq <= SMP_SQ_W'(smp_mag) * SMP_SQ_W'(smp_mag);
            end
            rsem_pkg::OP_MUL_INIT: begin
                r_mag   <= sum_mag;
                r_mbits <= sum_mag;
                r_prod  <= '0;
            end
            rsem_pkg::OP_MUL_STEP: begin
                r_prod  <= {r_prod[2*SUM_W-2:0], 1'b0}
                         + (r_mbits[SUM_W-1] ? (2*SUM_W)'(r_mag) : '0);
                r_mbits <= {r_mbits[SUM_W-2:0], 1'b0};
            end
            rsem_pkg::OP_DIV1_INIT: begin
                r_z   <= DIV_W'(r_prod);
                r_rem <= '0;
                r_div <= DVW'(r_count);
            end
            rsem_pkg::OP_DIV_STEP: begin
                r_rem <= div_ge ? DVW'(div_t - {1'b0, r_div}) : DVW'(div_t);
                r_z   <= {r_z[DIV_W-2:0], div_ge};
            end
            rsem_pkg::OP_DIV2_INIT: begin
                r_z   <= DIV_W'(d_var);
                r_rem <= '0;
                r_div <= DVW'(r_count - 1'b1) * DVW'(r_count);
            end
            rsem_pkg::OP_SQRT_INIT: begin
                r_v   <= r_z[RT_W-1:0];
                r_res <= '0;
                r_bit <= RT_W'(1) << (RT_W - 2);
            end
            rsem_pkg::OP_SQRT_STEP: begin
                if (r_v >= rt_try) begin
                    r_v   <= r_v - rt_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            rsem_pkg::OP_SE: begin
                r_se <= (r_res > RT_W'(rsem_pkg::SE_MAX)) ? rsem_pkg::SE_MAX
                                                          : r_res[rsem_pkg::SE_W-1:0];
            end
            rsem_pkg::OP_WIDTH: begin
                r_wid  <= wid_val;
                r_conv <= !o_status.count_lt2 && (wid_val <= r_tol);
            end
            rsem_pkg::OP_ZERO: begin
                r_se   <= '0;
                r_wid  <= '0;
                r_conv <= 1'b0;
            end
            rsem_pkg::OP_PUBLISH: begin
                o_std_error      <= r_se;
                o_interval_width <= r_wid;
                o_count_out      <= r_count;
                o_converged      <= r_conv;
                o_count_full     <= r_full;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/running_standard_error_monitor.sv
// top level of the running standard error monitor
// usage:
//   i_in carries one word per item: cmd 0 adds sample (signed Q10.10) to the
//   running sums, cmd 1 clears them. every item gives one word on o_out with
//   the standard error, the 99% interval half-width, the count, the converged flag
//   and the count_full flag (sample dropped because the count is saturated).
//   i_cfg_we / i_cfg_data write the tolerance on interval width (reset 1024).
// timing:
//   one item at a time; i_in.ready is high only while the sequencer is idle.
//   with n >= 2 an item runs through the bit-serial square of the sum, two
//   restoring divisions of DIV_W steps and a 32-step square root before
//   o_out.valid; with n < 2 or after a clear these are skipped and the
//   results are zeroed. a new item is accepted only after the last result
//   has been published to the output register.
// reset:
//   synchronous, active low; sums and count go to zero, tolerance to 1024.
// stall:
//   a result held in the output register lets the next item be accepted; if
//   the receiver still holds it when the next result is ready, the block waits.
`default_nettype none
module running_standard_error_monitor #(
    parameter int SAMPLE_WIDTH = 20,
    parameter int COUNT_WIDTH  = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    rsem_in_if.sink                         i_in,
    rsem_out_if.source                      o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [rsem_pkg::TOL_W-1:0] i_cfg_data
);
    localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int DIV_W = (2 * SUM_W > rsem_pkg::SQ_W) ? 2 * SUM_W : rsem_pkg::SQ_W;

    rsem_pkg::t_op     op;
    rsem_pkg::t_status status;

    rsem_ctrl #(
        .SUM_W (SUM_W),
        .DIV_W (DIV_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_op        (op)
    );

    rsem_dpath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SUM_W        (SUM_W),
        .DIV_W        (DIV_W)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_cmd            (i_in.cmd),
        .i_sample         (i_in.sample),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_status         (status),
        .o_std_error      (o_out.std_error),
        .o_interval_width (o_out.interval_width),
        .o_count_out      (o_out.count_out),
        .o_converged      (o_out.converged),
        .o_count_full     (o_out.count_full)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken again while busy");

    a_conv_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.converged |-> o_out.count_out >= COUNT_WIDTH'(2))
        else $error("converged with fewer than two samples");

    a_full_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.count_full |-> &o_out.count_out)
        else $error("count_full below maximum count");
`endif
endmodule
`default_nettype wire
